[design/tspc_pkg.sv]
// Shared types and constants for the thick segment pixel coverage block.
package tspc_pkg;

  localparam int PIX_W      = 12;  // pixel coordinate width, signed
  localparam int COORD_W    = 16;  // endpoint width, signed fixed point
  localparam int HW_W       = 10;  // half thickness width, unsigned fixed point
  localparam int DIM_REG_W  = 11;  // screen width and height register width
  localparam int INK_W      = 8;   // palette index width
  localparam int ADDR_W     = 20;  // framebuffer address width
  localparam int AC_W       = 32;  // magnitude of cross product kept for squaring
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X        = 3'd0,
    CFG_START_Y        = 3'd1,
    CFG_END_X          = 3'd2,
    CFG_END_Y          = 3'd3,
    CFG_HALF_THICKNESS = 3'd4,
    CFG_SCREEN_WIDTH   = 3'd5,
    CFG_SCREEN_HEIGHT  = 3'd6,
    CFG_INK            = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] pixel_address;
    logic [INK_W-1:0]  pixel_value;
  } out_item_t;

  // Load enables of the five internal pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_ld_t;

endpackage

[design/tspc_geom.sv]
// Five-stage datapath for the capsule distance test.
module tspc_geom #(
  parameter int FRAC_BITS = 4
) (
  input  logic                                  clk_i,
  input  tspc_pkg::pipe_ld_t                    ld_i,
  input  logic signed [tspc_pkg::PIX_W-1:0]     pixel_x_i,
  input  logic signed [tspc_pkg::PIX_W-1:0]     pixel_y_i,
  input  logic signed [tspc_pkg::COORD_W-1:0]   start_x_i,
  input  logic signed [tspc_pkg::COORD_W-1:0]   start_y_i,
  input  logic signed [tspc_pkg::COORD_W-1:0]   end_x_i,
  input  logic signed [tspc_pkg::COORD_W-1:0]   end_y_i,
  input  logic [tspc_pkg::HW_W-1:0]             half_thickness_i,
  output logic                                  covered_o
);

  localparam int QW   = tspc_pkg::PIX_W + FRAC_BITS;
  localparam int DW   = ((QW > tspc_pkg::COORD_W) ? QW : tspc_pkg::COORD_W) + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int HW2W = 2 * tspc_pkg::HW_W;
  localparam int RW   = HW2W + SW;
  localparam int SQW  = 2 * tspc_pkg::AC_W;
  localparam int MW   = (RW > SQW) ? RW : SQW;

  // Stage 1: differences against both endpoints
  logic signed [QW-1:0] qx, qy;
  logic signed [DW-1:0] px_d, py_d, rx_d, ry_d, vx_d, vy_d;
  logic signed [DW-1:0] px_q, py_q, rx_q, ry_q, vx_q, vy_q;
  logic [tspc_pkg::HW_W-1:0] hw_q;

  assign qx   = QW'(pixel_x_i) <<< FRAC_BITS;
  assign qy   = QW'(pixel_y_i) <<< FRAC_BITS;
  assign px_d = DW'(qx) - DW'(start_x_i);
  assign py_d = DW'(qy) - DW'(start_y_i);
  assign rx_d = DW'(qx) - DW'(end_x_i);
  assign ry_d = DW'(qy) - DW'(end_y_i);
  assign vx_d = DW'(end_x_i) - DW'(start_x_i);
  assign vy_d = DW'(end_y_i) - DW'(start_y_i);

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      px_q <= px_d;
      py_q <= py_d;
      rx_q <= rx_d;
      ry_q <= ry_d;
      vx_q <= vx_d;
      vy_q <= vy_d;
      hw_q <= half_thickness_i;
    end
  end

  // Stage 2: all products
  logic signed [PW-1:0] pxx_q, pyy_q, rxx_q, ryy_q, vxx_q, vyy_q;
  logic signed [PW-1:0] pxvx_q, pyvy_q, pxvy_q, pyvx_q;
  logic [HW2W-1:0]      hw2_2_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      pxx_q   <= px_q * px_q;
      pyy_q   <= py_q * py_q;
      rxx_q   <= rx_q * rx_q;
      ryy_q   <= ry_q * ry_q;
      vxx_q   <= vx_q * vx_q;
      vyy_q   <= vy_q * vy_q;
      pxvx_q  <= px_q * vx_q;
      pyvy_q  <= py_q * vy_q;
      pxvy_q  <= px_q * vy_q;
      pyvx_q  <= py_q * vx_q;
      hw2_2_q <= hw_q * hw_q;
    end
  end

  // Stage 3: sums
  logic signed [SW-1:0] d0_q, d1_q, dot_q, len2_q, cross_q;
  logic [HW2W-1:0]      hw2_3_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      d0_q    <= SW'(pxx_q) + SW'(pyy_q);
      d1_q    <= SW'(rxx_q) + SW'(ryy_q);
      dot_q   <= SW'(pxvx_q) + SW'(pyvy_q);
      len2_q  <= SW'(vxx_q) + SW'(vyy_q);
      cross_q <= SW'(pxvy_q) - SW'(pyvx_q);
      hw2_3_q <= hw2_2_q;
    end
  end

  // Stage 4: region decision and cross magnitude
  logic [SW-1:0]                ac_d;
  logic                         degen_4_q, beyond_4_q, near0_4_q, near1_4_q, big_4_q;
  logic [tspc_pkg::AC_W-1:0]    acl_q;
  logic [SW-1:0]                len2u_q;
  logic [HW2W-1:0]              hw2_4_q;

  assign ac_d = cross_q[SW-1] ? $unsigned(-cross_q) : $unsigned(cross_q);

  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      degen_4_q  <= (len2_q == '0) || (dot_q <= 0);
      beyond_4_q <= dot_q >= len2_q;
      near0_4_q  <= $unsigned(d0_q) <= SW'(hw2_3_q);
      near1_4_q  <= $unsigned(d1_q) <= SW'(hw2_3_q);
      big_4_q    <= |ac_d[SW-1:tspc_pkg::AC_W];
      acl_q      <= ac_d[tspc_pkg::AC_W-1:0];
      len2u_q    <= $unsigned(len2_q);
      hw2_4_q    <= hw2_3_q;
    end
  end

  // Stage 5: squared cross against half width squared times length squared
  logic [SQW-1:0] ac2_q;
  logic [RW-1:0]  rhs_q;
  logic           degen_5_q, beyond_5_q, near0_5_q, near1_5_q, big_5_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.s5) begin
      ac2_q      <= acl_q * acl_q;
      rhs_q      <= hw2_4_q * len2u_q;
      degen_5_q  <= degen_4_q;
      beyond_5_q <= beyond_4_q;
      near0_5_q  <= near0_4_q;
      near1_5_q  <= near1_4_q;
      big_5_q    <= big_4_q;
    end
  end

  always_comb begin
    if (degen_5_q) begin
      covered_o = near0_5_q;
    end else if (beyond_5_q) begin
      covered_o = near1_5_q;
    end else begin
      covered_o = !big_5_q && (MW'(ac2_q) <= MW'(rhs_q));
    end
  end

endmodule

[design/tspc_addr.sv]
// Screen bounds check and framebuffer address pipeline, aligned to the datapath.
module tspc_addr #(
  parameter int MAX_SCREEN_DIM = 1024
) (
  input  logic                                clk_i,
  input  tspc_pkg::pipe_ld_t                  ld_i,
  input  logic signed [tspc_pkg::PIX_W-1:0]   pixel_x_i,
  input  logic signed [tspc_pkg::PIX_W-1:0]   pixel_y_i,
  input  logic [tspc_pkg::DIM_REG_W-1:0]      screen_width_i,
  input  logic [tspc_pkg::DIM_REG_W-1:0]      screen_height_i,
  output logic                                on_screen_o,
  output logic [tspc_pkg::ADDR_W-1:0]         address_o
);

  localparam int DIM_W = $clog2(MAX_SCREEN_DIM + 1);
  localparam int CLW   = tspc_pkg::PIX_W;
  localparam int CW    = CLW - 1;
  localparam int PRW   = CW + DIM_W;
  localparam int ADW   = (PRW + 1 > tspc_pkg::ADDR_W) ? PRW + 1 : tspc_pkg::ADDR_W;

  logic [DIM_W-1:0] w_d, h_d;
  logic             on_d;

  // Saturate the screen size to the largest supported dimension
  assign w_d = (CLW'(screen_width_i) > CLW'(MAX_SCREEN_DIM)) ?
               DIM_W'(MAX_SCREEN_DIM) : DIM_W'(screen_width_i);
  assign h_d = (CLW'(screen_height_i) > CLW'(MAX_SCREEN_DIM)) ?
               DIM_W'(MAX_SCREEN_DIM) : DIM_W'(screen_height_i);

  assign on_d = !pixel_x_i[CLW-1] && !pixel_y_i[CLW-1] &&
                ($unsigned(pixel_x_i) < CLW'(w_d)) &&
                ($unsigned(pixel_y_i) < CLW'(h_d));

  logic             on1_q, on2_q, on3_q, on4_q, on5_q;
  logic [CW-1:0]    x1_q, y1_q, x2_q;
  logic [DIM_W-1:0] w1_q;
  logic [PRW-1:0]   prod_q;
  logic [ADW-1:0]   sum_d;
  logic [tspc_pkg::ADDR_W-1:0] addr3_q, addr4_q, addr5_q;

  assign sum_d = ADW'(prod_q) + ADW'(x2_q);

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      on1_q <= on_d;
      x1_q  <= pixel_x_i[CW-1:0];
      y1_q  <= pixel_y_i[CW-1:0];
      w1_q  <= w_d;
    end
    if (ld_i.s2) begin
      on2_q  <= on1_q;
      prod_q <= y1_q * w1_q;
      x2_q   <= x1_q;
    end
    if (ld_i.s3) begin
      on3_q   <= on2_q;
      addr3_q <= sum_d[tspc_pkg::ADDR_W-1:0];
    end
    if (ld_i.s4) begin
      on4_q   <= on3_q;
      addr4_q <= addr3_q;
    end
    if (ld_i.s5) begin
      on5_q   <= on4_q;
      addr5_q <= addr4_q;
    end
  end

  assign on_screen_o = on5_q;
  assign address_o   = addr5_q;

endmodule

[design/thick_segment_pixel_coverage.sv]
// Top level of the thick segment pixel coverage block.
//
//   channel   direction  handshake                   payload
//   in        input      in_valid_i / in_stall_o     in_item_i  (pixel_x, pixel_y)
//   out       output     out_valid_o / out_stall_i   out_item_o (hit, address, value)
//   cfg       input      cfg_we_i                    cfg_index_i, cfg_wdata_i
//
// One pixel enters per clock unless the output stalls; after its transfer a result
// passes five datapath stages and the output register, a depth set by the multiply
// chain of the capsule test: differences, products, sums, compare, squared cross.
// Reset restores the register defaults and empties the pipeline; no clearing pass.
// Each stage advances when it is empty or the stage after it advances, so a stall
// at the output fills bubbles first and only then holds the input.
module thick_segment_pixel_coverage #(
  parameter int FRAC_BITS      = 4,
  parameter int MAX_SCREEN_DIM = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tspc_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tspc_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [tspc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tspc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int NSTG = 5;

  // Configuration registers
  logic signed [tspc_pkg::COORD_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic [tspc_pkg::HW_W-1:0]           half_thickness_q;
  logic [tspc_pkg::DIM_REG_W-1:0]      screen_width_q, screen_height_q;
  logic [tspc_pkg::INK_W-1:0]          ink_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q        <= '0;
      start_y_q        <= '0;
      end_x_q          <= '0;
      end_y_q          <= '0;
      half_thickness_q <= '0;
      screen_width_q   <= tspc_pkg::DIM_REG_W'(1024);
      screen_height_q  <= tspc_pkg::DIM_REG_W'(1024);
      ink_q            <= '0;
    end else if (cfg_we_i) begin
      case (tspc_pkg::cfg_reg_e'(cfg_index_i))
        tspc_pkg::CFG_START_X:        start_x_q        <= cfg_wdata_i;
        tspc_pkg::CFG_START_Y:        start_y_q        <= cfg_wdata_i;
        tspc_pkg::CFG_END_X:          end_x_q          <= cfg_wdata_i;
        tspc_pkg::CFG_END_Y:          end_y_q          <= cfg_wdata_i;
        tspc_pkg::CFG_HALF_THICKNESS: half_thickness_q <= cfg_wdata_i[tspc_pkg::HW_W-1:0];
        tspc_pkg::CFG_SCREEN_WIDTH:   screen_width_q   <= cfg_wdata_i[tspc_pkg::DIM_REG_W-1:0];
        tspc_pkg::CFG_SCREEN_HEIGHT:  screen_height_q  <= cfg_wdata_i[tspc_pkg::DIM_REG_W-1:0];
        tspc_pkg::CFG_INK:            ink_q            <= cfg_wdata_i[tspc_pkg::INK_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and load enables; index 0 is the first stage
  logic [NSTG-1:0]    vld_q;
  logic [NSTG-1:0]    ld;
  logic               out_ld;
  logic               out_valid_q;
  tspc_pkg::pipe_ld_t pipe_ld;

  assign out_ld = !out_valid_q || !out_stall_i;

  always_comb begin
    ld[NSTG-1] = !vld_q[NSTG-1] || out_ld;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  assign pipe_ld.s1 = ld[0];
  assign pipe_ld.s2 = ld[1];
  assign pipe_ld.s3 = ld[2];
  assign pipe_ld.s4 = ld[3];
  assign pipe_ld.s5 = ld[4];

  assign in_stall_o = !ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (out_ld) begin
        out_valid_q <= vld_q[NSTG-1];
      end
    end
  end

  // Distance test and address datapaths
  logic                          covered;
  logic                          on_screen;
  logic [tspc_pkg::ADDR_W-1:0]   address;

  tspc_geom #(
    .FRAC_BITS(FRAC_BITS)
  ) u_geom (
    .clk_i           (clk_i),
    .ld_i            (pipe_ld),
    .pixel_x_i       (in_item_i.pixel_x),
    .pixel_y_i       (in_item_i.pixel_y),
    .start_x_i       (start_x_q),
    .start_y_i       (start_y_q),
    .end_x_i         (end_x_q),
    .end_y_i         (end_y_q),
    .half_thickness_i(half_thickness_q),
    .covered_o       (covered)
  );

  tspc_addr #(
    .MAX_SCREEN_DIM(MAX_SCREEN_DIM)
  ) u_addr (
    .clk_i          (clk_i),
    .ld_i           (pipe_ld),
    .pixel_x_i      (in_item_i.pixel_x),
    .pixel_y_i      (in_item_i.pixel_y),
    .screen_width_i (screen_width_q),
    .screen_height_i(screen_height_q),
    .on_screen_o    (on_screen),
    .address_o      (address)
  );

  // Output register: hold while stalled, zero the address on a miss
  tspc_pkg::out_item_t out_item_q;
  logic                hit_d;

  assign hit_d = on_screen && covered;

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_item_q.hit           <= hit_d;
      out_item_q.pixel_address <= hit_d ? address : '0;
      out_item_q.pixel_value   <= ink_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[design/tspc_checker.sv]
// Port-level checker for the thick segment pixel coverage block, with its bind.
module tspc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input tspc_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tspc_pkg::out_item_t out_item_o
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_valid_o && out_stall_i) |-> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // Drive a zero address for every miss
  a_miss_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.hit |-> out_item_o.pixel_address == '0)
    else $error("miss carries a nonzero address");

  // Push back at the input only when the output holds a stalled result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // Leave reset with an empty output
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present right after reset");

endmodule

bind thick_segment_pixel_coverage tspc_checker u_tspc_checker (.*);
